>>> hdl/apgt_pkg.sv
package apgt_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FIELD_W     = 16;
    localparam int DIFF_W      = FIELD_W + 1;
    localparam int RAD_W       = 2 * FIELD_W;
    localparam int REM_W       = FIELD_W + 1;
    localparam int ROOT_STEPS  = RAD_W / 2;
    localparam int CNT_W       = $clog2(ROOT_STEPS);

    localparam logic signed [DIFF_W-1:0] SAT_HI = DIFF_W'((2 ** (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [DIFF_W-1:0] SAT_LO = -SAT_HI - DIFF_W'(1);

    localparam logic [FIELD_W-1:0] MAG_MAX = FIELD_W'(46341);

    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_CLEAR  = 2'd1;
    localparam logic [1:0] ACT_SEED   = 2'd2;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_LATERAL      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_LONGITUDINAL = 1'd1;

    typedef struct packed {
        logic [1:0]                action;
        logic signed [FIELD_W-1:0] lateral_sample;
        logic signed [FIELD_W-1:0] longitudinal_sample;
        logic [FIELD_W-1:0]        seed_left;
        logic [FIELD_W-1:0]        seed_right;
        logic [FIELD_W-1:0]        seed_forward;
        logic [FIELD_W-1:0]        seed_brake;
    } t_in_item;

    typedef struct packed {
        logic signed [FIELD_W-1:0] lateral_g;
        logic signed [FIELD_W-1:0] longitudinal_g;
        logic [FIELD_W-1:0]        magnitude_g;
        logic [FIELD_W-1:0]        peak_left;
        logic [FIELD_W-1:0]        peak_right;
        logic [FIELD_W-1:0]        peak_forward;
        logic [FIELD_W-1:0]        peak_brake;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_MUL_LAT = 5'b00010,
        S_MUL_LON = 5'b00100,
        S_ROOT    = 5'b01000,
        S_DONE    = 5'b10000
    } t_state;

endpackage

>>> hdl/accel_peak_g_tracker.sv
// Two-axis peak-hold g meter.
// Input channel (i_in_valid / o_in_stall, payload i_in_data): one transfer per
// action: new sample, clear peaks or seed peaks. Action code 3 changes nothing.
// Output channel (o_out_valid / i_out_stall, payload o_out_data): exactly one
// transfer per input item, carrying the last corrected sample, its magnitude
// and the four held peaks after the action.
// Config channel (i_cfg_valid / o_cfg_ready): offset registers, always ready;
// write only while the block is idle.
// Steps: a sample has its two squares formed on the shared multiplier, then
// goes through the two-bits-per-cycle square root and is committed. Clear,
// seed and ignored actions go straight to the commit. o_in_stall is high from
// input transfer until the result is committed, so a new item is taken only
// after the last one has been committed.
// A result waiting under i_out_stall does not block the next input transfer;
// the commit of that next item waits until the pending result is taken.
// Reset (i_rst_n low, synchronous) zeroes offsets, last values and peaks and
// drops any item in flight.
module accel_peak_g_tracker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  apgt_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output apgt_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [apgt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [apgt_pkg::FIELD_W-1:0]   i_cfg_data
);

    localparam int W = apgt_pkg::FIELD_W;

    apgt_pkg::t_state r_state, n_state;

    logic signed [W-1:0] r_off_lat, r_off_lon;
    logic signed [W-1:0] r_last_lat, n_last_lat, r_last_lon, n_last_lon;
    logic [W-1:0] r_last_mag, n_last_mag;
    logic [W-1:0] r_hold_left, n_hold_left, r_hold_right, n_hold_right;
    logic [W-1:0] r_hold_fwd, n_hold_fwd, r_hold_brake, n_hold_brake;
    logic r_out_valid, n_out_valid;

    apgt_pkg::t_in_item r_item;
    logic signed [W-1:0] r_lat, r_lon;
    logic [W-1:0] r_abs_lat, r_abs_lon;
    logic [apgt_pkg::RAD_W-1:0] r_rad, n_rad;
    logic [apgt_pkg::REM_W-1:0] r_rem, n_rem;
    logic [W-1:0] r_root, n_root;
    logic [apgt_pkg::CNT_W-1:0] r_cnt, n_cnt;

    logic in_xfer, out_free;
    logic signed [apgt_pkg::DIFF_W-1:0] diff_lat, diff_lon;
    logic signed [W-1:0] sat_lat, sat_lon;
    logic [W-1:0] mul_a;
    logic [apgt_pkg::RAD_W-1:0] mul_p;
    logic [apgt_pkg::REM_W+1:0] rem_sh, trial, rem_sub;

    function automatic logic signed [W-1:0] sat_fn(input logic signed [apgt_pkg::DIFF_W-1:0] v);
        logic signed [W-1:0] res;
        if (v > apgt_pkg::SAT_HI) begin
            res = W'(apgt_pkg::SAT_HI);
        end else if (v < apgt_pkg::SAT_LO) begin
            res = W'(apgt_pkg::SAT_LO);
        end else begin
            res = W'(v);
        end
        return res;
    endfunction

    function automatic logic [W-1:0] abs_fn(input logic signed [W-1:0] v);
        return v[W-1] ? W'(-v) : W'(v);
    endfunction

    function automatic logic [W-1:0] max_fn(input logic [W-1:0] a, input logic [W-1:0] b);
        return (b > a) ? b : a;
    endfunction

    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != apgt_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;

    assign o_out_data.lateral_g      = r_last_lat;
    assign o_out_data.longitudinal_g = r_last_lon;
    assign o_out_data.magnitude_g    = r_last_mag;
    assign o_out_data.peak_left      = r_hold_left;
    assign o_out_data.peak_right     = r_hold_right;
    assign o_out_data.peak_forward   = r_hold_fwd;
    assign o_out_data.peak_brake     = r_hold_brake;

    assign diff_lat = $signed({i_in_data.lateral_sample[W-1], i_in_data.lateral_sample})
                    - $signed({r_off_lat[W-1], r_off_lat});
    assign diff_lon = $signed({i_in_data.longitudinal_sample[W-1],
                               i_in_data.longitudinal_sample})
                    - $signed({r_off_lon[W-1], r_off_lon});
    assign sat_lat = sat_fn(diff_lat);
    assign sat_lon = sat_fn(diff_lon);

    // shared multiplier
    assign mul_a = r_state[1] ? r_abs_lat : r_abs_lon;
    assign mul_p = apgt_pkg::RAD_W'(mul_a) * apgt_pkg::RAD_W'(mul_a);

    // one root digit per cycle
    assign rem_sh  = {r_rem, r_rad[apgt_pkg::RAD_W-1 -: 2]};
    assign trial   = {1'b0, r_root, 2'b01};
    assign rem_sub = rem_sh - trial;

    always_comb begin
        n_state      = r_state;
        n_rad        = r_rad;
        n_rem        = r_rem;
        n_root       = r_root;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid && i_out_stall;
        n_last_lat   = r_last_lat;
        n_last_lon   = r_last_lon;
        n_last_mag   = r_last_mag;
        n_hold_left  = r_hold_left;
        n_hold_right = r_hold_right;
        n_hold_fwd   = r_hold_fwd;
        n_hold_brake = r_hold_brake;
        case (r_state)
            apgt_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_state = (i_in_data.action == apgt_pkg::ACT_SAMPLE)
                            ? apgt_pkg::S_MUL_LAT : apgt_pkg::S_DONE;
                end
            end
            apgt_pkg::S_MUL_LAT: begin
                n_rad   = mul_p;
                n_state = apgt_pkg::S_MUL_LON;
            end
            apgt_pkg::S_MUL_LON: begin
                n_rad   = r_rad + mul_p;
                n_rem   = '0;
                n_root  = '0;
                n_cnt   = apgt_pkg::CNT_W'(apgt_pkg::ROOT_STEPS - 1);
                n_state = apgt_pkg::S_ROOT;
            end
            apgt_pkg::S_ROOT: begin
                n_rad = {r_rad[apgt_pkg::RAD_W-3:0], 2'b00};
                if (!rem_sub[apgt_pkg::REM_W+1]) begin
                    n_rem  = rem_sub[apgt_pkg::REM_W-1:0];
                    n_root = {r_root[W-2:0], 1'b1};
                end else begin
                    n_rem  = rem_sh[apgt_pkg::REM_W-1:0];
                    n_root = {r_root[W-2:0], 1'b0};
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = apgt_pkg::S_DONE;
                end
            end
            apgt_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = apgt_pkg::S_IDLE;
                    case (r_item.action)
                        apgt_pkg::ACT_SAMPLE: begin
                            n_last_lat = r_lat;
                            n_last_lon = r_lon;
                            n_last_mag = r_root;
                            if (r_lat[W-1]) begin
                                n_hold_left = max_fn(r_hold_left, r_abs_lat);
                            end else begin
                                n_hold_right = max_fn(r_hold_right, r_abs_lat);
                            end
                            if (!r_lon[W-1] && (r_lon != '0)) begin
                                n_hold_fwd = max_fn(r_hold_fwd, r_abs_lon);
                            end else begin
                                n_hold_brake = max_fn(r_hold_brake, r_abs_lon);
                            end
                        end
                        apgt_pkg::ACT_CLEAR: begin
                            n_hold_left  = '0;
                            n_hold_right = '0;
                            n_hold_fwd   = '0;
                            n_hold_brake = '0;
                        end
                        apgt_pkg::ACT_SEED: begin
                            n_hold_left  = max_fn(r_hold_left, r_item.seed_left);
                            n_hold_right = max_fn(r_hold_right, r_item.seed_right);
                            n_hold_fwd   = max_fn(r_hold_fwd, r_item.seed_forward);
                            n_hold_brake = max_fn(r_hold_brake, r_item.seed_brake);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = apgt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= apgt_pkg::S_IDLE;
            r_out_valid  <= 1'b0;
            r_off_lat    <= '0;
            r_off_lon    <= '0;
            r_last_lat   <= '0;
            r_last_lon   <= '0;
            r_last_mag   <= '0;
            r_hold_left  <= '0;
            r_hold_right <= '0;
            r_hold_fwd   <= '0;
            r_hold_brake <= '0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_last_lat   <= n_last_lat;
            r_last_lon   <= n_last_lon;
            r_last_mag   <= n_last_mag;
            r_hold_left  <= n_hold_left;
            r_hold_right <= n_hold_right;
            r_hold_fwd   <= n_hold_fwd;
            r_hold_brake <= n_hold_brake;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == apgt_pkg::REG_OFFSET_LATERAL) begin
                    r_off_lat <= i_cfg_data;
                end
                if (i_cfg_index == apgt_pkg::REG_OFFSET_LONGITUDINAL) begin
                    r_off_lon <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_cnt  <= n_cnt;
        if (in_xfer) begin
            r_item    <= i_in_data;
            r_lat     <= sat_lat;
            r_lon     <= sat_lon;
            r_abs_lat <= abs_fn(sat_lat);
            r_abs_lon <= abs_fn(sat_lon);
        end
    end

endmodule

>>> hdl/apgt_checker.sv
module apgt_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input apgt_pkg::t_out_item o_out_data
);

    // result holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output changed while stalled");

    // one item in flight at a time
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while busy");

    // a new result only comes out of a busy cycle
    a_result_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without an item");

    a_mag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.magnitude_g <= apgt_pkg::MAG_MAX))
        else $error("magnitude out of range");

endmodule

bind accel_peak_g_tracker apgt_checker u_apgt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
